@@ src/sik_pkg.sv @@
// Shared types, constants and the arctangent table for the SCARA inverse kinematics core.
`timescale 1ns / 1ps
`default_nettype none
package sik_pkg;

    localparam int CORDIC_STAGES_DEF = 16;

    // APB register map
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_LINK1     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LINK2     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LIFT_MIN  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LIFT_MAX  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BASE      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ANGLE_LIM = 3'd5;

    localparam logic [12:0]        RST_LINK1     = 13'd1065;
    localparam logic [12:0]        RST_LINK2     = 13'd1254;
    localparam logic signed [15:0] RST_LIFT_MIN  = -16'sd486;
    localparam logic signed [15:0] RST_LIFT_MAX  = -16'sd51;
    localparam logic signed [15:0] RST_BASE      = 16'sd458;
    localparam logic [14:0]        RST_ANGLE_LIM = 15'd16640;

    // Square root of a radicand below 2^54: one result bit per step
    localparam int SQRT_STEPS = 27;
    localparam int SQRT_W     = 55;

    // Vectoring unit widths; angles in 2^-24 degree
    localparam int CORD_IN_W  = 30;
    localparam int NORM_TOP   = 40;
    localparam int NORM_W     = NORM_TOP + 2;
    localparam int NORM_STEPS = 6;
    localparam int CORD_W     = NORM_W + 2;
    localparam int ANG_W      = 34;
    localparam logic signed [ANG_W-1:0] ANG_90 = 34'sd1509949440;

    typedef struct packed {
        logic signed [15:0] target_x;
        logic signed [15:0] target_height;
        logic signed [15:0] target_z;
    } t_ik_in;

    typedef struct packed {
        logic signed [15:0] shoulder_angle;
        logic signed [15:0] elbow_angle;
        logic signed [15:0] lift_position;
        logic               reachable;
    } t_ik_out;

    // atan(2^-idx) in 2^-24 degree, rounded to nearest
    function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:  v = 34'sd754974720;
            1:  v = 34'sd445687602;
            2:  v = 34'sd235489088;
            3:  v = 34'sd119537938;
            4:  v = 34'sd60000934;
            5:  v = 34'sd30029717;
            6:  v = 34'sd15018523;
            7:  v = 34'sd7509720;
            8:  v = 34'sd3754917;
            9:  v = 34'sd1877466;
            10: v = 34'sd938734;
            11: v = 34'sd469367;
            12: v = 34'sd234684;
            13: v = 34'sd117342;
            14: v = 34'sd58671;
            15: v = 34'sd29335;
            16: v = 34'sd14668;
            17: v = 34'sd7334;
            18: v = 34'sd3667;
            19: v = 34'sd1833;
            20: v = 34'sd917;
            21: v = 34'sd458;
            22: v = 34'sd229;
            23: v = 34'sd115;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ src/sik_cordic.sv @@
// Pipelined atan2 vectoring unit: normalize, quadrant fold, then one rotation per stage.
`timescale 1ns / 1ps
`default_nettype none
module sik_cordic #(
    parameter int STAGES = sik_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_en,
    input  wire logic signed [sik_pkg::CORD_IN_W-1:0]  i_y,
    input  wire logic signed [sik_pkg::CORD_IN_W-1:0]  i_x,
    output logic signed [sik_pkg::ANG_W-1:0]           o_angle
);
    localparam int IW = sik_pkg::CORD_IN_W;
    localparam int NW = sik_pkg::NORM_W;
    localparam int MW = sik_pkg::NORM_TOP + 1;
    localparam int NS = sik_pkg::NORM_STEPS;
    localparam int CW = sik_pkg::CORD_W;
    localparam int AW = sik_pkg::ANG_W;

    // normalize stages
    logic signed [NW-1:0] r_nx [NS];
    logic signed [NW-1:0] r_ny [NS];
    logic [MW-1:0]        r_nm [NS];
    logic                 r_nz [NS];
    logic signed [NW-1:0] w_nx_in [NS];
    logic signed [NW-1:0] w_ny_in [NS];
    logic [MW-1:0]        w_nm_in [NS];
    logic                 w_nz_in [NS];
    logic                 w_go    [NS];
    logic signed [NW-1:0] n_nx [NS];
    logic signed [NW-1:0] n_ny [NS];
    logic [MW-1:0]        n_nm [NS];

    logic [IW-1:0] w_ax;
    logic [IW-1:0] w_ay;

    // quadrant fold stage
    logic signed [CW-1:0] r_px;
    logic signed [CW-1:0] r_py;
    logic signed [AW-1:0] r_pa;
    logic                 r_pz;
    logic signed [CW-1:0] w_fx;
    logic signed [CW-1:0] w_fy;

    // rotation stages
    logic signed [CW-1:0] r_cx [STAGES];
    logic signed [CW-1:0] r_cy [STAGES];
    logic signed [AW-1:0] r_ca [STAGES];
    logic                 r_cz [STAGES];
    logic signed [CW-1:0] w_cx_in [STAGES];
    logic signed [CW-1:0] w_cy_in [STAGES];
    logic signed [AW-1:0] w_ca_in [STAGES];
    logic                 w_cz_in [STAGES];
    logic signed [CW-1:0] n_cx [STAGES];
    logic signed [CW-1:0] n_cy [STAGES];
    logic signed [AW-1:0] n_ca [STAGES];

    assign w_ax = i_x[IW-1] ? IW'(-i_x) : IW'(i_x);
    assign w_ay = i_y[IW-1] ? IW'(-i_y) : IW'(i_y);

    for (genvar j = 0; j < NS; j++) begin : g_norm
        localparam int SH = 1 << (NS - 1 - j);
        if (j == 0) begin : g_first
            assign w_nx_in[j] = NW'(i_x);
            assign w_ny_in[j] = NW'(i_y);
            assign w_nm_in[j] = {{(MW - IW){1'b0}}, w_ax | w_ay};
            assign w_nz_in[j] = (i_x == '0) && (i_y == '0);
        end else begin : g_next
            assign w_nx_in[j] = r_nx[j-1];
            assign w_ny_in[j] = r_ny[j-1];
            assign w_nm_in[j] = r_nm[j-1];
            assign w_nz_in[j] = r_nz[j-1];
        end
        // shift only while the leading one stays at or below the top position
        assign w_go[j] = (w_nm_in[j] >> (MW - SH)) == '0;
        assign n_nx[j] = w_go[j] ? (w_nx_in[j] <<< SH) : w_nx_in[j];
        assign n_ny[j] = w_go[j] ? (w_ny_in[j] <<< SH) : w_ny_in[j];
        assign n_nm[j] = w_go[j] ? (w_nm_in[j] << SH) : w_nm_in[j];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < NS; j++) begin
                r_nx[j] <= n_nx[j];
                r_ny[j] <= n_ny[j];
                r_nm[j] <= n_nm[j];
                r_nz[j] <= w_nz_in[j];
            end
        end
    end

    assign w_fx = CW'(r_nx[NS-1]);
    assign w_fy = CW'(r_ny[NS-1]);

    // fold the left half plane onto the right one
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pz <= r_nz[NS-1];
            if (w_fx < 0) begin
                if (w_fy >= 0) begin
                    r_px <= w_fy;
                    r_py <= -w_fx;
                    r_pa <= sik_pkg::ANG_90;
                end else begin
                    r_px <= -w_fy;
                    r_py <= w_fx;
                    r_pa <= -sik_pkg::ANG_90;
                end
            end else begin
                r_px <= w_fx;
                r_py <= w_fy;
                r_pa <= '0;
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_rot
        logic signed [CW-1:0] w_xs;
        logic signed [CW-1:0] w_ys;
        logic                 w_neg;
        if (i == 0) begin : g_first
            assign w_cx_in[i] = r_px;
            assign w_cy_in[i] = r_py;
            assign w_ca_in[i] = r_pa;
            assign w_cz_in[i] = r_pz;
        end else begin : g_next
            assign w_cx_in[i] = r_cx[i-1];
            assign w_cy_in[i] = r_cy[i-1];
            assign w_ca_in[i] = r_ca[i-1];
            assign w_cz_in[i] = r_cz[i-1];
        end
        assign w_xs    = w_cx_in[i] >>> i;
        assign w_ys    = w_cy_in[i] >>> i;
        assign w_neg   = w_cy_in[i][CW-1];
        assign n_cx[i] = w_neg ? (w_cx_in[i] - w_ys) : (w_cx_in[i] + w_ys);
        assign n_cy[i] = w_neg ? (w_cy_in[i] + w_xs) : (w_cy_in[i] - w_xs);
        assign n_ca[i] = w_neg ? (w_ca_in[i] - sik_pkg::atan_entry(i))
                               : (w_ca_in[i] + sik_pkg::atan_entry(i));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < STAGES; i++) begin
                r_cx[i] <= n_cx[i];
                r_cy[i] <= n_cy[i];
                r_ca[i] <= n_ca[i];
                r_cz[i] <= w_cz_in[i];
            end
        end
    end

    // both operands zero give angle zero
    assign o_angle = r_cz[STAGES-1] ? '0 : r_ca[STAGES-1];

endmodule
`default_nettype wire

@@ src/scara_inverse_kinematics_core.sv @@
// Top level of the SCARA inverse kinematics core: APB registers, reach test, sqrt, angles, lift.
// The pipeline has 7 setup stages, 27 square root stages, 7 + CORDIC_STAGES atan2 stages
// and 3 output stages. Throughput: one request per cycle; the whole pipeline holds while a
// result waits at the output. Reset clears the valid bits and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module scara_inverse_kinematics_core #(
    parameter int CORDIC_STAGES = sik_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire sik_pkg::t_ik_in               i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output sik_pkg::t_ik_out                   o_out_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sik_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    localparam int SQ  = sik_pkg::SQRT_STEPS;
    localparam int SW  = sik_pkg::SQRT_W;
    localparam int CL  = sik_pkg::NORM_STEPS + 1 + CORDIC_STAGES;
    localparam int LAT = 7 + SQ + CL + 3;
    localparam int IW  = sik_pkg::CORD_IN_W;
    localparam int AW  = sik_pkg::ANG_W;

    typedef struct packed {
        logic               reach;
        logic signed [15:0] lift;
        logic signed [27:0] num;
        logic signed [29:0] t;
        logic signed [15:0] x;
        logic signed [15:0] z;
    } t_sq_side;

    typedef struct packed {
        logic               reach;
        logic signed [15:0] lift;
    } t_cd_side;

    // configuration
    logic [12:0]        r_link1;
    logic [12:0]        r_link2;
    logic signed [15:0] r_lift_min;
    logic signed [15:0] r_lift_max;
    logic signed [15:0] r_base;
    logic [14:0]        r_angle_lim;
    logic [sik_pkg::REG_IDX_W-1:0] w_idx;

    // values that follow from the configuration only
    logic [13:0]        w_lsum;
    logic [12:0]        w_ldif;
    logic [25:0]        w_l1l2;
    logic [27:0]        r_sum_sq;
    logic [25:0]        r_dif_sq;
    logic [25:0]        r_l1sq;
    logic [25:0]        r_l2sq;
    logic [26:0]        r_den;
    logic [53:0]        r_den_sq;
    logic signed [16:0] r_span;

    logic           w_en;
    logic [LAT-1:0] r_vld;

    // setup stages
    logic signed [15:0] r1_x, r1_h, r1_z;
    logic signed [31:0] w_xx, w_zz;
    logic [30:0]        r2_xx, r2_zz;
    logic signed [16:0] r2_dh;
    logic signed [15:0] r2_x, r2_z;
    logic [31:0]        r3_d2;
    logic signed [33:0] r3_prod;
    logic signed [15:0] r3_x, r3_z;
    logic signed [33:0] w_lround;
    logic signed [26:0] w_lraw;
    logic               r4_reach;
    logic signed [33:0] r4_num;
    logic signed [26:0] r4_lift;
    logic signed [15:0] r4_x, r4_z;
    logic signed [33:0] w_den34;
    logic signed [33:0] w_numc;
    logic signed [26:0] w_lmin, w_lmax, w_la, w_lb;
    logic               r5_reach;
    logic signed [27:0] r5_num;
    logic signed [15:0] r5_lift, r5_x, r5_z;
    logic signed [55:0] w_nsq;
    logic               r6_reach;
    logic [53:0]        r6_nsq;
    logic signed [27:0] r6_num;
    logic signed [29:0] r6_t;
    logic signed [15:0] r6_lift, r6_x, r6_z;
    logic [SW-1:0]      r7_rad;
    t_sq_side           r7_side;

    // square root stages
    logic [SW-1:0] r_sq_v [SQ];
    logic [SW-1:0] r_sq_r [SQ];
    t_sq_side      r_sq_side [SQ];
    logic [SW-1:0] w_sv_in [SQ];
    logic [SW-1:0] w_sr_in [SQ];
    logic [SW:0]   w_ssum  [SQ];
    logic          w_sge   [SQ];
    logic [SW-1:0] n_sq_v  [SQ];
    logic [SW-1:0] n_sq_r  [SQ];

    // angle stages
    logic signed [IW-1:0] w_s;
    logic signed [IW-1:0] w_num_c;
    logic signed [IW-1:0] w_t_c;
    logic signed [IW-1:0] w_x_c;
    logic signed [IW-1:0] w_z_c;
    logic signed [AW-1:0] w_a_e, w_a_zx, w_a_st;
    t_cd_side             r_cd [CL];

    logic signed [AW:0]   r_p1_sh, r_p1_e;
    t_cd_side             r_p1_side;
    logic signed [AW:0]   w_sh_rnd, w_e_rnd;
    logic signed [17:0]   r_p2_sh, r_p2_e;
    t_cd_side             r_p2_side;
    logic signed [17:0]   w_lim;
    logic signed [17:0]   w_sh_c, w_e_c;
    sik_pkg::t_ik_out     r_out;

    // ---------------- APB registers ----------------
    assign w_idx  = paddr[sik_pkg::ADDR_W-1:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link1     <= sik_pkg::RST_LINK1;
            r_link2     <= sik_pkg::RST_LINK2;
            r_lift_min  <= sik_pkg::RST_LIFT_MIN;
            r_lift_max  <= sik_pkg::RST_LIFT_MAX;
            r_base      <= sik_pkg::RST_BASE;
            r_angle_lim <= sik_pkg::RST_ANGLE_LIM;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                sik_pkg::REG_LINK1:     r_link1     <= pwdata[12:0];
                sik_pkg::REG_LINK2:     r_link2     <= pwdata[12:0];
                sik_pkg::REG_LIFT_MIN:  r_lift_min  <= pwdata[15:0];
                sik_pkg::REG_LIFT_MAX:  r_lift_max  <= pwdata[15:0];
                sik_pkg::REG_BASE:      r_base      <= pwdata[15:0];
                sik_pkg::REG_ANGLE_LIM: r_angle_lim <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            sik_pkg::REG_LINK1:     prdata = {19'b0, r_link1};
            sik_pkg::REG_LINK2:     prdata = {19'b0, r_link2};
            sik_pkg::REG_LIFT_MIN:  prdata = {16'b0, r_lift_min};
            sik_pkg::REG_LIFT_MAX:  prdata = {16'b0, r_lift_max};
            sik_pkg::REG_BASE:      prdata = {16'b0, r_base};
            sik_pkg::REG_ANGLE_LIM: prdata = {17'b0, r_angle_lim};
            default:                prdata = '0;
        endcase
    end

    // configuration products, registered; the den square is taken from the registered r_den
    assign w_lsum = {1'b0, r_link1} + {1'b0, r_link2};
    assign w_ldif = (r_link1 >= r_link2) ? (r_link1 - r_link2) : (r_link2 - r_link1);
    assign w_l1l2 = {13'b0, r_link1} * {13'b0, r_link2};

    always_ff @(posedge i_clk) begin
        r_sum_sq <= {14'b0, w_lsum} * {14'b0, w_lsum};
        r_dif_sq <= {13'b0, w_ldif} * {13'b0, w_ldif};
        r_l1sq   <= {13'b0, r_link1} * {13'b0, r_link1};
        r_l2sq   <= {13'b0, r_link2} * {13'b0, r_link2};
        r_den    <= {w_l1l2, 1'b0};
        r_den_sq <= {27'b0, r_den} * {27'b0, r_den};
        r_span   <= 17'(r_lift_max) - 17'(r_lift_min);
    end

    // ---------------- flow control ----------------
    assign w_en        = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[LAT-1];
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    // ---------------- setup stages ----------------
    assign w_xx = 32'(r1_x) * 32'(r1_x);
    assign w_zz = 32'(r1_z) * 32'(r1_z);

    assign w_lround = r3_prod + 34'sd256;
    assign w_lraw   = 27'($signed(w_lround[33:9])) + 27'(r_lift_min);

    assign w_den34 = $signed({7'b0, r_den});
    always_comb begin
        if (r4_num > w_den34) begin
            w_numc = w_den34;
        end else if (r4_num < -w_den34) begin
            w_numc = -w_den34;
        end else begin
            w_numc = r4_num;
        end
    end

    // raise to lift_min, then lower to lift_max
    assign w_lmin = 27'(r_lift_min);
    assign w_lmax = 27'(r_lift_max);
    assign w_la   = (r4_lift < w_lmin) ? w_lmin : r4_lift;
    assign w_lb   = (w_la > w_lmax) ? w_lmax : w_la;

    assign w_nsq = 56'(r5_num) * 56'(r5_num);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_x <= i_in_data.target_x;
            r1_h <= i_in_data.target_height;
            r1_z <= i_in_data.target_z;

            r2_xx <= w_xx[30:0];
            r2_zz <= w_zz[30:0];
            r2_dh <= 17'(r1_h) - 17'(r_base);
            r2_x  <= r1_x;
            r2_z  <= r1_z;

            r3_d2   <= {1'b0, r2_xx} + {1'b0, r2_zz};
            r3_prod <= 34'(r_span) * 34'(r2_dh);
            r3_x    <= r2_x;
            r3_z    <= r2_z;

            r4_reach <= (r3_d2 <= {4'b0, r_sum_sq}) && (r3_d2 >= {6'b0, r_dif_sq});
            r4_num   <= $signed({2'b0, r3_d2}) - $signed({8'b0, r_l1sq})
                        - $signed({8'b0, r_l2sq});
            r4_lift  <= w_lraw;
            r4_x     <= r3_x;
            r4_z     <= r3_z;

            r5_reach <= r4_reach;
            r5_num   <= w_numc[27:0];
            r5_lift  <= w_lb[15:0];
            r5_x     <= r4_x;
            r5_z     <= r4_z;

            r6_reach <= r5_reach;
            r6_nsq   <= w_nsq[53:0];
            r6_num   <= r5_num;
            r6_t     <= $signed({3'b0, r_l1sq, 1'b0}) + 30'(r5_num);
            r6_lift  <= r5_lift;
            r6_x     <= r5_x;
            r6_z     <= r5_z;

            r7_rad        <= {1'b0, r_den_sq - r6_nsq};
            r7_side.reach <= r6_reach;
            r7_side.lift  <= r6_lift;
            r7_side.num   <= r6_num;
            r7_side.t     <= r6_t;
            r7_side.x     <= r6_x;
            r7_side.z     <= r6_z;
        end
    end

    // ---------------- square root, one result bit per stage ----------------
    for (genvar k = 0; k < SQ; k++) begin : g_sqrt
        localparam logic [SW-1:0] BIT = SW'(1) << (2 * (SQ - 1 - k));
        if (k == 0) begin : g_first
            assign w_sv_in[k] = r7_rad;
            assign w_sr_in[k] = '0;
        end else begin : g_next
            assign w_sv_in[k] = r_sq_v[k-1];
            assign w_sr_in[k] = r_sq_r[k-1];
        end
        assign w_ssum[k] = {1'b0, w_sr_in[k]} + {1'b0, BIT};
        assign w_sge[k]  = {1'b0, w_sv_in[k]} >= w_ssum[k];
        assign n_sq_v[k] = w_sge[k] ? (w_sv_in[k] - w_ssum[k][SW-1:0]) : w_sv_in[k];
        assign n_sq_r[k] = w_sge[k] ? ((w_sr_in[k] >> 1) + BIT) : (w_sr_in[k] >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_side[0] <= r7_side;
            for (int k = 0; k < SQ; k++) begin
                r_sq_v[k] <= n_sq_v[k];
                r_sq_r[k] <= n_sq_r[k];
            end
            for (int k = 1; k < SQ; k++) begin
                r_sq_side[k] <= r_sq_side[k-1];
            end
        end
    end

    // ---------------- three atan2 units ----------------
    assign w_s     = $signed({3'b0, r_sq_r[SQ-1][26:0]});
    assign w_num_c = IW'(r_sq_side[SQ-1].num);
    assign w_t_c   = r_sq_side[SQ-1].t;
    assign w_x_c   = IW'(r_sq_side[SQ-1].x);
    assign w_z_c   = IW'(r_sq_side[SQ-1].z);

    sik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_elbow (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_y     (w_s),
        .i_x     (w_num_c),
        .o_angle (w_a_e)
    );

    sik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_target (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_y     (w_z_c),
        .i_x     (w_x_c),
        .o_angle (w_a_zx)
    );

    sik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_offset (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_y     (w_s),
        .i_x     (w_t_c),
        .o_angle (w_a_st)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cd[0].reach <= r_sq_side[SQ-1].reach;
            r_cd[0].lift  <= r_sq_side[SQ-1].lift;
            for (int c = 1; c < CL; c++) begin
                r_cd[c] <= r_cd[c-1];
            end
        end
    end

    // ---------------- difference, rounding, saturation ----------------
    assign w_sh_rnd = r_p1_sh + (AW + 1)'(65536);
    assign w_e_rnd  = r_p1_e + (AW + 1)'(65536);

    assign w_lim  = $signed({3'b0, r_angle_lim});
    assign w_sh_c = (r_p2_sh > w_lim) ? w_lim : ((r_p2_sh < -w_lim) ? -w_lim : r_p2_sh);
    assign w_e_c  = (r_p2_e > w_lim) ? w_lim : ((r_p2_e < -w_lim) ? -w_lim : r_p2_e);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_sh   <= (AW + 1)'(w_a_zx) - (AW + 1)'(w_a_st);
            r_p1_e    <= (AW + 1)'(w_a_e);
            r_p1_side <= r_cd[CL-1];

            r_p2_sh   <= w_sh_rnd[AW:17];
            r_p2_e    <= w_e_rnd[AW:17];
            r_p2_side <= r_p1_side;

            // drop everything but the flag when out of reach
            if (r_p2_side.reach) begin
                r_out.shoulder_angle <= w_sh_c[15:0];
                r_out.elbow_angle    <= w_e_c[15:0];
                r_out.lift_position  <= r_p2_side.lift;
                r_out.reachable      <= 1'b1;
            end else begin
                r_out <= '0;
            end
        end
    end

endmodule
`default_nettype wire

@@ src/sik_port_checker.sv @@
// Port-level assertions for the SCARA inverse kinematics core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sik_port_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       o_in_ready,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_ready,
    input wire sik_pkg::t_ik_out           o_out_data
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed or vanished");

    // an empty output never blocks a request
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output");

    // a waiting result blocks new requests
    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("request taken while result stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind scara_inverse_kinematics_core sik_port_checker u_sik_port_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
`default_nettype wire

@@ verif/scara_inverse_kinematics_core_test.sv @@
// Self-checking testbench for the SCARA inverse kinematics core.
`timescale 1ns / 1ps
`default_nettype none
module scara_inverse_kinematics_core_test;

    localparam int STAGES = sik_pkg::CORDIC_STAGES_DEF;
    localparam longint LIMIT_CYCLES = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_fire = 1'b0;
    logic o_in_ready;
    sik_pkg::t_ik_in in_data = '0;
    logic o_out_valid;
    logic out_ready = 1'b0;
    sik_pkg::t_ik_out o_out_data;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [sik_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    scara_inverse_kinematics_core #(.CORDIC_STAGES(STAGES)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(o_in_ready), .i_in_data(in_data),
        .o_out_valid(o_out_valid), .i_out_ready(out_ready), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow of the arm geometry
    longint link1, link2, lift_lo, lift_hi, base_h, ang_lim;
    sik_pkg::t_ik_in pending_targets[$];
    sik_pkg::t_ik_out expected_setpoints[$];
    bit failed = 1'b0;
    longint cycle_count = 0;

    function automatic longint shr_floor(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint root64(longint v);
        longint r, b;
        r = 0;
        b = 64'sh4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint a, t, xs, ys;
        a = 0;
        if (x == 0 && y == 0) return 0;
        while ((x < 0 ? -x : x) < (64'sd1 <<< 40) && (y < 0 ? -y : y) < (64'sd1 <<< 40)) begin
            x = x * 2;
            y = y * 2;
        end
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; a = 64'sd90 * 16777216;
            end else begin
                t = x; x = -y; y = t; a = -64'sd90 * 16777216;
            end
        end
        for (int i = 0; i < STAGES && i < 24; i++) begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            if (y >= 0) begin
                x = x + ys; y = y - xs; a = a + longint'(sik_pkg::atan_entry(i));
            end else begin
                x = x - ys; y = y + xs; a = a - longint'(sik_pkg::atan_entry(i));
            end
        end
        return a;
    endfunction

    function automatic longint to_joint(longint a);
        longint v;
        v = shr_floor(a + (64'sd1 <<< 16), 17);
        if (v > ang_lim) v = ang_lim;
        if (v < -ang_lim) v = -ang_lim;
        return v;
    endfunction

    function automatic sik_pkg::t_ik_out solve_arm(sik_pkg::t_ik_in t);
        sik_pkg::t_ik_out r;
        longint x, h, z, d2, sum, dif, num, den, s, e, sh, lift;
        x = t.target_x;
        h = t.target_height;
        z = t.target_z;
        d2 = x * x + z * z;
        sum = link1 + link2;
        dif = link1 - link2;
        r = '0;
        if (d2 > sum * sum || d2 < dif * dif) return r;
        num = d2 - link1 * link1 - link2 * link2;
        den = 2 * link1 * link2;
        if (num > den) num = den;
        if (num < -den) num = -den;
        s = root64(den * den - num * num);
        e = vector_angle(s, num);
        sh = vector_angle(z, x) - vector_angle(s, 2 * link1 * link1 + num);
        lift = lift_lo + shr_floor((lift_hi - lift_lo) * (h - base_h) + 256, 9);
        if (lift < lift_lo) lift = lift_lo;
        if (lift > lift_hi) lift = lift_hi;
        r.shoulder_angle = 16'(to_joint(sh));
        r.elbow_angle = 16'(to_joint(e));
        r.lift_position = 16'(lift);
        r.reachable = 1'b1;
        return r;
    endfunction

    function automatic void queue_target(sik_pkg::t_ik_in t);
        pending_targets.insert(pending_targets.size(), t);
    endfunction

    // driver: one request per item with a random gap after each
    int in_gap = 0;
    always @(negedge i_clk) begin
        if (in_valid && !in_fire) begin
            // hold
        end else if (in_gap > 0) begin
            in_valid <= 1'b0;
            in_gap <= in_gap - 1;
        end else if (pending_targets.size() > 0) begin
            in_data <= pending_targets.pop_front();
            in_valid <= 1'b1;
            in_gap <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 5);
        end else begin
            in_valid <= 1'b0;
        end
    end

    // predict on acceptance, check on delivery
    int out_gap = 0;
    always @(posedge i_clk) begin
        sik_pkg::t_ik_out want;
        cycle_count <= cycle_count + 1;
        in_fire <= i_rst_n && in_valid && o_in_ready;
        if (i_rst_n && in_valid && o_in_ready)
            expected_setpoints.insert(expected_setpoints.size(), solve_arm(in_data));
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_setpoints.size() == 0) begin
                $error("unexpected result %h", o_out_data);
                failed = 1'b1;
            end else begin
                want = expected_setpoints.pop_front();
                if (o_out_data.shoulder_angle !== want.shoulder_angle) begin
                    $error("shoulder_angle exp %0d got %0d",
                           want.shoulder_angle, o_out_data.shoulder_angle);
                    failed = 1'b1;
                end
                if (o_out_data.elbow_angle !== want.elbow_angle) begin
                    $error("elbow_angle exp %0d got %0d",
                           want.elbow_angle, o_out_data.elbow_angle);
                    failed = 1'b1;
                end
                if (o_out_data.lift_position !== want.lift_position) begin
                    $error("lift_position exp %0d got %0d",
                           want.lift_position, o_out_data.lift_position);
                    failed = 1'b1;
                end
                if (o_out_data.reachable !== want.reachable) begin
                    $error("reachable exp %0d got %0d", want.reachable, o_out_data.reachable);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (out_gap > 0) begin
            out_ready <= 1'b0;
            out_gap <= out_gap - 1;
        end else begin
            out_ready <= 1'b1;
            if (o_out_valid) out_gap <= $urandom_range(0, 2) == 0 ? $urandom_range(0, 5) : 0;
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [sik_pkg::REG_IDX_W-1:0] idx, input longint value);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            sik_pkg::REG_LINK1:     link1 = value & 13'h1FFF;
            sik_pkg::REG_LINK2:     link2 = value & 13'h1FFF;
            sik_pkg::REG_LIFT_MIN:  lift_lo = longint'(signed'(16'(value)));
            sik_pkg::REG_LIFT_MAX:  lift_hi = longint'(signed'(16'(value)));
            sik_pkg::REG_BASE:      base_h = longint'(signed'(16'(value)));
            sik_pkg::REG_ANGLE_LIM: ang_lim = value & 15'h7FFF;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_targets.size() > 0 || in_valid || expected_setpoints.size() > 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic sik_pkg::t_ik_in make_target(longint x, longint h, longint z);
        sik_pkg::t_ik_in t;
        t.target_x = 16'(x);
        t.target_height = 16'(h);
        t.target_z = 16'(z);
        return t;
    endfunction

    // polar target near the reach annulus, plus some raw noise
    function automatic sik_pkg::t_ik_in random_target();
        real r, th, lo, hi;
        if ($urandom_range(0, 4) == 0)
            return make_target($urandom_range(0, 65535), $urandom_range(0, 65535),
                               $urandom_range(0, 65535));
        lo = link1 > link2 ? link1 - link2 : link2 - link1;
        hi = link1 + link2;
        r = lo - 4 + (hi - lo + 8) * ($urandom_range(0, 10000) / 10000.0);
        th = 6.2831853 * ($urandom_range(0, 10000) / 10000.0);
        r = r * $cos(th);
        lo = (hi - 4 + 8 * ($urandom_range(0, 100) / 100.0)) * $sin(th);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        if (lo > 32767) lo = 32767;
        if (lo < -32768) lo = -32768;
        if ($urandom_range(0, 1)) lo = (lo / hi) * (r == 0 ? 1 : hi) * 0 + lo;
        return make_target(longint'(r), $urandom_range(0, 65535),
                           longint'((hi - lo) == 0 ? lo : lo * ($urandom_range(0, 1) ? 1 : 0.7)));
    endfunction

    initial begin
        link1 = sik_pkg::RST_LINK1; link2 = sik_pkg::RST_LINK2;
        lift_lo = sik_pkg::RST_LIFT_MIN; lift_hi = sik_pkg::RST_LIFT_MAX;
        base_h = sik_pkg::RST_BASE; ang_lim = sik_pkg::RST_ANGLE_LIM;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: axes, full reach, folded, origin, field extremes
        queue_target(make_target(2319, 0, 0));
        queue_target(make_target(-2319, 0, 0));
        queue_target(make_target(0, 0, 2319));
        queue_target(make_target(0, 0, -2319));
        queue_target(make_target(189, 458, 0));
        queue_target(make_target(0, 32767, 0));
        queue_target(make_target(32767, -32768, 32767));
        queue_target(make_target(-32768, 32767, -32768));
        queue_target(make_target(-1000, -32768, -1000));
        queue_target(make_target(1500, 12345, -900));
        drain();

        // equal links and zero lengths, inverted lift range, zero angle limit
        write_reg(sik_pkg::REG_LINK1, 1000);
        write_reg(sik_pkg::REG_LINK2, 1000);
        write_reg(sik_pkg::REG_LIFT_MIN, 500);
        write_reg(sik_pkg::REG_LIFT_MAX, -500);
        write_reg(sik_pkg::REG_ANGLE_LIM, 0);
        queue_target(make_target(0, 0, 0));
        queue_target(make_target(2000, 100, 0));
        queue_target(make_target(-2000, 100, 0));
        drain();
        write_reg(sik_pkg::REG_LINK1, 0);
        queue_target(make_target(1000, 0, 0));
        queue_target(make_target(0, 0, -1000));
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(sik_pkg::REG_LINK1, 8191);
                    write_reg(sik_pkg::REG_LINK2, 8191);
                    write_reg(sik_pkg::REG_LIFT_MIN, -32768);
                    write_reg(sik_pkg::REG_LIFT_MAX, 32767);
                    write_reg(sik_pkg::REG_BASE, -32768);
                    write_reg(sik_pkg::REG_ANGLE_LIM, 23040);
                end
                1: begin
                    write_reg(sik_pkg::REG_LINK1, 1);
                    write_reg(sik_pkg::REG_LINK2, 8191);
                    write_reg(sik_pkg::REG_BASE, 32767);
                end
                2: begin
                    write_reg(sik_pkg::REG_LINK1, sik_pkg::RST_LINK1);
                    write_reg(sik_pkg::REG_LINK2, sik_pkg::RST_LINK2);
                    write_reg(sik_pkg::REG_LIFT_MIN, sik_pkg::RST_LIFT_MIN);
                    write_reg(sik_pkg::REG_LIFT_MAX, sik_pkg::RST_LIFT_MAX);
                    write_reg(sik_pkg::REG_BASE, sik_pkg::RST_BASE);
                    write_reg(sik_pkg::REG_ANGLE_LIM, sik_pkg::RST_ANGLE_LIM);
                end
                default: begin
                    write_reg(sik_pkg::REG_LINK1, $urandom_range(1, 8191));
                    write_reg(sik_pkg::REG_LINK2, $urandom_range(1, 8191));
                    write_reg(sik_pkg::REG_LIFT_MIN, $urandom_range(0, 65535));
                    write_reg(sik_pkg::REG_LIFT_MAX, $urandom_range(0, 65535));
                    write_reg(sik_pkg::REG_BASE, $urandom_range(0, 65535));
                    write_reg(sik_pkg::REG_ANGLE_LIM, $urandom_range(0, 23040));
                end
            endcase
            for (int n = 0; n < 300; n++) queue_target(random_target());
            drain();
        end

        if (!failed) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
